// ===== rtl/windowed_mean_max_std_history_top_assert.svh =====
// assertion macros for the windowed cost statistics block
// used by windowed_mean_max_std_history_top only
`ifndef WINDOWED_MEAN_MAX_STD_HISTORY_TOP_ASSERT_SVH
`define WINDOWED_MEAN_MAX_STD_HISTORY_TOP_ASSERT_SVH

// implication checked every clock, off during reset
`define WMS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wmsh_pkg.sv =====
// types and constants shared by the windowed cost statistics block
// no dependencies
`default_nettype none
package wmsh_pkg;
   localparam int COST_W = 24;
   localparam int SLOT_W = 4;
   localparam logic CMD_COST  = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   typedef struct packed {
      logic                     cmd;
      logic signed [COST_W-1:0] cost;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]        slot;
      logic signed [COST_W-1:0] mean_out;
      logic signed [COST_W-1:0] max_out;
      logic [COST_W-1:0]        std_out;
      logic                     dropped;
      logic                     last;
   } rsp_type;

   // one history entry as stored in memory
   typedef struct packed {
      logic [COST_W-1:0] mean;
      logic [COST_W-1:0] maxv;
      logic [COST_W-1:0] stdv;
      logic              dropped;
   } hist_type;
endpackage
`default_nettype wire

// ===== rtl/wmsh_divu.sv =====
// unsigned restoring divider, one quotient bit per cycle
// uses no package
`default_nettype none
module wmsh_divu #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num; r_in = '0; cnt_in = CNT_W'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ===== rtl/windowed_mean_max_std_history_top.sv =====
// windowed cost statistics: accumulator, close sequencer, history memory, readout
// depends on wmsh_pkg, wmsh_divu and windowed_mean_max_std_history_top_assert.svh
//
// usage:
//   req channel (req_valid/req_stall/req_data) carries one item per cycle
//   while req_stall is low. cmd cost adds a Q12.12 value to the open cycle,
//   taken one per clock and producing no result; past MAX_COSTS a cost is
//   not added but marks the entry dropped. cmd close ends the cycle: the
//   block computes mean, max and population std, writes them into the history
//   memory and sends HISTORY_LEN slot items on rsp
//   (rsp_valid/rsp_stall/rsp_data), oldest first, last set on the final one.
//   unfilled leading slots read as zero. a non-empty close runs through the
//   datapath as a multiply in two halves, a difference, 31 root steps, two
//   32-bit serial divides and a memory write; an empty close skips to the
//   write. each slot then goes through a memory read and an output load.
//   req_stall is high for the whole close sequence, readout included; cost
//   items run at one per cycle.
//   rsp_stall holds the current slot item in the output register.
//   reset (synchronous) clears accumulators, history pointers and the
//   per-entry valid bits, so entries read as zero until written.
`default_nettype none
module windowed_mean_max_std_history_top #(
   parameter int HISTORY_LEN = 10,
   parameter int MAX_COSTS   = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire wmsh_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output wmsh_pkg::rsp_type     rsp_data
);
   import wmsh_pkg::*;

   localparam int IDX_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam int HC_W  = $clog2(HISTORY_LEN + 1);
   localparam int CNT_W = 7;
   localparam int SUM_W = 31;
   localparam int SQ_W  = 53;
   localparam int P_W   = 60;   // n * sumsq
   localparam int RT_W  = 31;   // sqrt of 62-bit value

   typedef enum logic [8:0] {
      ST_ACC   = 9'b000000001,
      ST_MUL   = 9'b000000010,  // p = n*sumsq, q = s*s
      ST_MUL2  = 9'b000000100,
      ST_SQRT  = 9'b000001000,
      ST_DIVM  = 9'b000010000,
      ST_DIVS  = 9'b000100000,
      ST_WRITE = 9'b001000000,
      ST_READ  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // open-cycle accumulators
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic signed [COST_W-1:0] amax_ff, amax_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;

   // history control
   logic [IDX_W-1:0] newest_ff, newest_in;
   logic [HC_W-1:0]  hcnt_ff, hcnt_in;
   logic [HISTORY_LEN-1:0] vld_ff, vld_in;

   // close datapath
   logic [P_W-1:0]   p_ff, p_in;
   logic [P_W-1:0]   q_ff, q_in;
   logic [SUM_W-1:0] abs_s;
   logic [P_W+1:0]   d_ff, d_in;      // sqrt radicand work
   logic [RT_W+1:0]  root_ff, root_in;
   logic [RT_W+1:0]  rrem_ff, rrem_in;
   logic [5:0]       scnt_ff, scnt_in;
   logic [COST_W-1:0] mean_ff, mean_in, std_ff, std_in;
   logic             neg_ff, neg_in;
   logic             mulsel_ff, mulsel_in;

   // readout
   logic [IDX_W:0]   k_ff, k_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W:0]   kr_ff, kr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // memory
   hist_type mem [HISTORY_LEN];
   hist_type mem_rd_ff;
   logic     mem_we;
   logic [IDX_W-1:0] mem_wa;
   hist_type mem_wd;

   // divider
   logic             div_start, div_done;
   logic [31:0]      div_num, div_quot;

   wmsh_divu #(.NUM_W(32), .DEN_W(CNT_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(cnt_ff), .done(div_done), .quot(div_quot)
   );

   logic req_fire, rsp_fire;
   logic signed [COST_W-1:0] cost_v;
   logic [COST_W-1:0] abs_c;
   logic [IDX_W-1:0] wr_idx, oldest;
   logic [IDX_W:0]   empty;
   logic [IDX_W:0]   old_plus;
   logic [IDX_W:0]   rd_sum;
   logic [RT_W+2:0]  strial;
   logic [P_W+1:0]   dsh;

   assign req_stall = (state_ff != ST_ACC);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign cost_v    = req_data.cost;
   assign abs_c     = cost_v[COST_W-1] ? COST_W'(-cost_v) : COST_W'(cost_v);
   assign abs_s     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // slot addressing
   assign wr_idx = (hcnt_ff == '0) ? '0 :
                   ((newest_ff == IDX_W'(HISTORY_LEN - 1)) ? '0 : newest_ff + 1'b1);
   assign empty  = (IDX_W+1)'(HISTORY_LEN) - (IDX_W+1)'(hcnt_ff);
   assign old_plus = (IDX_W+1)'(newest_ff) + 1'b1 + (IDX_W+1)'(HISTORY_LEN)
                     - (IDX_W+1)'(hcnt_ff);
   assign oldest = (old_plus >= (IDX_W+1)'(HISTORY_LEN)) ?
                   IDX_W'(old_plus - (IDX_W+1)'(HISTORY_LEN)) : IDX_W'(old_plus);
   // ring position of slot k before the wrap
   assign rd_sum = (IDX_W+1)'(oldest) + (k_ff - empty);

   assign strial = {rrem_ff[RT_W:0], d_ff[P_W+1:P_W]};
   assign dsh    = {d_ff[P_W-1:0], 2'b00};

   always_comb begin
      state_in = state_ff;
      sum_in = sum_ff; sq_in = sq_ff; amax_in = amax_ff; cnt_in = cnt_ff; ovf_in = ovf_ff;
      newest_in = newest_ff; hcnt_in = hcnt_ff; vld_in = vld_ff;
      p_in = p_ff; q_in = q_ff; d_in = d_ff; root_in = root_ff; rrem_in = rrem_ff;
      scnt_in = scnt_ff; mean_in = mean_ff; std_in = std_ff; neg_in = neg_ff;
      mulsel_in = mulsel_ff;
      k_in = k_ff; rd_idx_in = rd_idx_ff; kr_in = kr_ff; rd_vld_in = 1'b0;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      mem_we = 1'b0; mem_wa = wr_idx; mem_wd = '0;
      div_start = 1'b0; div_num = '0;
      if (rsp_fire) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_ACC: begin
            if (req_fire) begin
               if (req_data.cmd == CMD_COST) begin
                  if (cnt_ff >= CNT_W'(MAX_COSTS)) begin
                     ovf_in = 1'b1;
                  end else begin
                     if (cnt_ff == '0 || cost_v > amax_ff) amax_in = cost_v;
                     sum_in = sum_ff + SUM_W'(cost_v);
                     sq_in  = sq_ff + SQ_W'(abs_c * abs_c);
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  mulsel_in = 1'b0;
                  state_in = (cnt_ff == '0) ? ST_WRITE : ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // n*sumsq in two halves: low 27 bits then high 26 bits
            if (!mulsel_ff) begin
               p_in = P_W'(sq_ff[26:0] * cnt_ff);
               q_in = P_W'(abs_s * abs_s);
               mulsel_in = 1'b1;
            end else begin
               p_in = p_ff + P_W'({P_W'(sq_ff[SQ_W-1:27] * cnt_ff), 27'b0});
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            d_in = (p_ff > q_ff) ? {2'b00, p_ff - q_ff} : '0;
            root_in = '0; rrem_in = '0; scnt_in = 6'd31;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // two radicand bits per step
            if (strial >= {1'b0, root_ff[RT_W-1:0], 2'b01}) begin
               rrem_in = (RT_W+2)'(strial - {1'b0, root_ff[RT_W-1:0], 2'b01});
               root_in = {root_ff[RT_W:0], 1'b1};
            end else begin
               rrem_in = strial[RT_W+1:0];
               root_in = {root_ff[RT_W:0], 1'b0};
            end
            d_in = dsh;
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == 6'd1) begin
               neg_in = sum_ff[SUM_W-1];
               div_start = 1'b1;
               div_num = 32'(abs_s);
               state_in = ST_DIVM;
            end
         end
         ST_DIVM: begin
            if (div_done) begin
               mean_in = neg_ff ? COST_W'(-div_quot) : COST_W'(div_quot);
               div_start = 1'b1;
               div_num = 32'(root_ff);
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            if (div_done) begin
               std_in = COST_W'(div_quot);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            if (cnt_ff != '0) begin
               mem_wd.mean = mean_ff; mem_wd.maxv = amax_ff;
               mem_wd.stdv = std_ff; mem_wd.dropped = ovf_ff;
            end
            vld_in[wr_idx] = 1'b1;
            newest_in = wr_idx;
            if (hcnt_ff < HC_W'(HISTORY_LEN)) hcnt_in = hcnt_ff + 1'b1;
            sum_in = '0; sq_in = '0; amax_in = '0; cnt_in = '0; ovf_in = 1'b0;
            k_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            // issue a read for slot k, wait for output register to drain
            if (!rsp_valid_ff || rsp_fire) begin
               rd_idx_in = (rd_sum >= (IDX_W+1)'(HISTORY_LEN)) ?
                  IDX_W'(rd_sum - (IDX_W+1)'(HISTORY_LEN)) : IDX_W'(rd_sum);
               kr_in = k_ff;
               rd_vld_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_in.slot = SLOT_W'(kr_ff);
            rsp_in.last = (kr_ff == (IDX_W+1)'(HISTORY_LEN - 1));
            if (kr_ff < empty || !vld_ff[rd_idx_ff]) begin
               rsp_in.mean_out = '0; rsp_in.max_out = '0;
               rsp_in.std_out = '0; rsp_in.dropped = 1'b0;
            end else begin
               rsp_in.mean_out = mem_rd_ff.mean; rsp_in.max_out = mem_rd_ff.maxv;
               rsp_in.std_out = mem_rd_ff.stdv; rsp_in.dropped = mem_rd_ff.dropped;
            end
            rsp_valid_in = 1'b1;
            k_in = k_ff + 1'b1;
            state_in = (kr_ff == (IDX_W+1)'(HISTORY_LEN - 1)) ? ST_ACC : ST_READ;
         end
         default: state_in = ST_ACC;
      endcase
   end

   // history memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (rd_vld_in) mem_rd_ff <= mem[rd_idx_in];
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; q_ff <= q_in; d_ff <= d_in; root_ff <= root_in; rrem_ff <= rrem_in;
      scnt_ff <= scnt_in; mean_ff <= mean_in; std_ff <= std_in; neg_ff <= neg_in;
      rd_idx_ff <= rd_idx_in; kr_ff <= kr_in; rsp_ff <= rsp_in; mulsel_ff <= mulsel_in;
      rd_vld_ff <= rd_vld_in;
      if (reset) begin
         state_ff <= ST_ACC;
         sum_ff <= '0; sq_ff <= '0; amax_ff <= '0; cnt_ff <= '0; ovf_ff <= 1'b0;
         newest_ff <= '0; hcnt_ff <= '0; vld_ff <= '0;
         k_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff <= sum_in; sq_ff <= sq_in; amax_ff <= amax_in;
         cnt_ff <= cnt_in; ovf_ff <= ovf_in;
         newest_ff <= newest_in; hcnt_ff <= hcnt_in; vld_ff <= vld_in;
         k_ff <= k_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "windowed_mean_max_std_history_top_assert.svh"
   `WMS_ASSERT_IMP(a_no_accept_busy, state_ff != ST_ACC, req_stall, "accept while busy")
   `WMS_ASSERT_NEXT(a_read_then_out, rd_vld_ff, state_ff == ST_READ || state_ff == ST_ACC,
      "read data not consumed")
   `WMS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(MAX_COSTS), "count beyond limit")
endmodule
`default_nettype wire
